/* src/kvie_pkg.sv */
// ----------------------------------------------------------------------------
// kvie_pkg
// Shared types, codes and helpers of the key/value integer extractor.
// ----------------------------------------------------------------------------
package kvie_pkg;

  localparam int KEY_MAX_BYTES_DEF = 8;
  localparam int KEY_TEXT_W        = 64;
  localparam int KEY_LEN_W         = 4;
  localparam int MAG_W             = 32;
  localparam int VALUE_W           = 33;
  localparam int STATUS_W          = 2;
  localparam int CFG_INDEX_W       = 2;
  localparam int S_TDATA_W         = 8;
  localparam int M_TDATA_W         = 40;

  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_TEXT    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_LENGTH  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SIGNED_MODE = 2'd2;

  localparam logic [7:0] CHAR_EQUALS = 8'h3D;
  localparam logic [7:0] CHAR_PLUS   = 8'h2B;
  localparam logic [7:0] CHAR_MINUS  = 8'h2D;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [7:0] CHAR_NUL    = 8'h00;

  localparam logic [MAG_W-1:0] INT_MAX_MAG = 32'h7FFF_FFFF;
  localparam logic [MAG_W-1:0] INT_MIN_MAG = 32'h8000_0000;

  typedef enum logic [2:0] {
    PH_SEEK   = 3'd0,
    PH_LEAD   = 3'd1,
    PH_SIGN   = 3'd2,
    PH_DIGITS = 3'd3,
    PH_DONE   = 3'd4
  } phase_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_NOKEY = 2'd1,
    ST_PARSE = 2'd2
  } status_t;

  typedef struct packed {
    logic [KEY_TEXT_W-1:0] key_text;
    logic [KEY_LEN_W-1:0]  key_length;
    logic                  signed_mode;
  } kvie_cfg_t;

  typedef struct packed {
    logic       fire;
    logic [7:0] text_byte;
    logic       last_byte;
  } kvie_step_t;

  typedef struct packed {
    status_t             status;
    logic [VALUE_W-1:0]  value;
  } kvie_result_t;

  typedef struct packed {
    phase_t            phase;
    logic [MAG_W-1:0]  magnitude;
    logic              negative_sign;
    logic              overflowed;
    logic              first_after_equals;
    status_t           held_status;
  } kvie_line_t;

  // space, TAB, LF, VT, FF, CR
  function automatic logic is_ws(input logic [7:0] b);
    return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
  endfunction

endpackage

/* src/kvie_scan.sv */
// ----------------------------------------------------------------------------
// kvie_scan
// Per-line scan state: key search over a short byte history, then the
// decimal value parser. One byte is folded in per step.
// ----------------------------------------------------------------------------
module kvie_scan import kvie_pkg::*; #(
  parameter int KEY_MAX_BYTES = KEY_MAX_BYTES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  kvie_step_t   step,
  input  kvie_cfg_t    cfg,
  output kvie_result_t result
);

  localparam int HIST_DEPTH = KEY_MAX_BYTES + 1;
  localparam int POS_W      = $clog2(KEY_MAX_BYTES + 2);
  localparam int PROD_W     = MAG_W + 4;

  localparam kvie_line_t LINE_CLEAR = '{
    phase:              PH_SEEK,
    magnitude:          '0,
    negative_sign:      1'b0,
    overflowed:         1'b0,
    first_after_equals: 1'b0,
    held_status:        ST_NOKEY
  };

  kvie_line_t       line;
  kvie_line_t       line_step;
  kvie_line_t       line_end;
  logic [POS_W-1:0] key_position;
  logic [POS_W-1:0] key_position_next;
  logic [7:0]       history      [HIST_DEPTH];
  logic [7:0]       history_next [HIST_DEPTH];

  logic [KEY_MAX_BYTES:1] len_match;
  logic [KEY_LEN_W-1:0]   key_len;
  logic                   key_hit;
  logic                   is_digit;
  logic                   byte_ws;
  logic [PROD_W-1:0]      prod;

  function automatic kvie_line_t add_digit(input kvie_line_t s, input logic [PROD_W-1:0] p);
    kvie_line_t r;
    r = s;
    if (!r.overflowed) begin
      if (|p[PROD_W-1:MAG_W]) begin
        r.overflowed = 1'b1;
      end else begin
        r.magnitude = p[MAG_W-1:0];
      end
    end
    return r;
  endfunction

  function automatic kvie_line_t finish_digits(input kvie_line_t s, input logic term_ok,
                                               input logic signed_mode);
    kvie_line_t r;
    logic       bad;
    r   = s;
    bad = !term_ok || r.overflowed;
    if (!bad) begin
      if (signed_mode) begin
        bad = r.negative_sign ? (r.magnitude > INT_MIN_MAG) : (r.magnitude > INT_MAX_MAG);
      end else begin
        bad = r.negative_sign && (r.magnitude != '0);
      end
    end
    if (bad) begin
      r.held_status   = ST_PARSE;
      r.magnitude     = '0;
      r.negative_sign = 1'b0;
    end else begin
      r.held_status = ST_OK;
    end
    r.phase = PH_DONE;
    return r;
  endfunction

  function automatic kvie_line_t finish_no_digits(input kvie_line_t s);
    kvie_line_t r;
    r = s;
    if (r.first_after_equals) begin
      r.held_status = ST_OK;
    end
    r.magnitude     = '0;
    r.negative_sign = 1'b0;
    r.phase         = PH_DONE;
    return r;
  endfunction

  function automatic kvie_line_t end_line(input kvie_line_t s, input logic signed_mode);
    kvie_line_t r;
    r = s;
    unique case (s.phase)
      PH_SEEK: begin
        r.held_status   = ST_NOKEY;
        r.magnitude     = '0;
        r.negative_sign = 1'b0;
        r.phase         = PH_DONE;
      end
      PH_LEAD, PH_SIGN: r = finish_no_digits(s);
      PH_DIGITS:        r = finish_digits(s, 1'b1, signed_mode);
      default: ;
    endcase
    return r;
  endfunction

  // Key match, evaluated for every possible key length; each candidate only
  // looks at fixed history taps.
  always_comb begin
    for (int k = 1; k <= KEY_MAX_BYTES; k++) begin
      len_match[k] = (key_position >= POS_W'(k)) &&
                     ((key_position == POS_W'(k)) || is_ws(history[k]));
      for (int i = 0; i < k; i++) begin
        if (history[k-1-i] != cfg.key_text[8*i +: 8]) begin
          len_match[k] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    if (cfg.key_length == '0) begin
      key_len = KEY_LEN_W'(1);
    end else if (cfg.key_length > KEY_LEN_W'(KEY_MAX_BYTES)) begin
      key_len = KEY_LEN_W'(KEY_MAX_BYTES);
    end else begin
      key_len = cfg.key_length;
    end
    key_hit = 1'b0;
    for (int k = 1; k <= KEY_MAX_BYTES; k++) begin
      if (key_len == KEY_LEN_W'(k)) begin
        key_hit = len_match[k];
      end
    end
  end

  // magnitude * 10 + digit
  assign is_digit = (step.text_byte >= CHAR_ZERO) && (step.text_byte <= CHAR_NINE);
  assign byte_ws  = is_ws(step.text_byte);
  assign prod     = (PROD_W'(line.magnitude) << 3) + (PROD_W'(line.magnitude) << 1)
                  + PROD_W'(step.text_byte[3:0]);

  // Next state for one byte
  always_comb begin
    line_step         = line;
    key_position_next = key_position;
    for (int i = 0; i < HIST_DEPTH; i++) begin
      history_next[i] = history[i];
    end
    if (step.text_byte == CHAR_NUL) begin
      line_step = end_line(line, cfg.signed_mode);
    end else begin
      unique case (line.phase)
        PH_SEEK: begin
          if (step.text_byte == CHAR_EQUALS && key_hit) begin
            line_step.phase              = PH_LEAD;
            line_step.first_after_equals = 1'b1;
            line_step.magnitude          = '0;
            line_step.negative_sign      = 1'b0;
            line_step.overflowed         = 1'b0;
          end else begin
            for (int i = HIST_DEPTH - 1; i > 0; i--) begin
              history_next[i] = history[i-1];
            end
            history_next[0] = step.text_byte;
            if (key_position < POS_W'(HIST_DEPTH)) begin
              key_position_next = key_position + POS_W'(1);
            end
          end
        end
        PH_LEAD: begin
          if (line_step.first_after_equals) begin
            line_step.held_status        = byte_ws ? ST_OK : ST_PARSE;
            line_step.first_after_equals = 1'b0;
          end
          if (byte_ws) begin
            // skip leading whitespace
          end else if (step.text_byte == CHAR_PLUS || step.text_byte == CHAR_MINUS) begin
            line_step.negative_sign = (step.text_byte == CHAR_MINUS);
            line_step.phase         = PH_SIGN;
          end else if (is_digit) begin
            line_step       = add_digit(line_step, prod);
            line_step.phase = PH_DIGITS;
          end else begin
            line_step = finish_no_digits(line_step);
          end
        end
        PH_SIGN: begin
          if (is_digit) begin
            line_step       = add_digit(line_step, prod);
            line_step.phase = PH_DIGITS;
          end else begin
            line_step = finish_no_digits(line_step);
          end
        end
        PH_DIGITS: begin
          if (is_digit) begin
            line_step = add_digit(line_step, prod);
          end else begin
            line_step = finish_digits(line_step, byte_ws, cfg.signed_mode);
          end
        end
        default: ;
      endcase
    end
  end

  // Result of the line, valid when the step carries the last byte
  always_comb begin
    line_end      = end_line(line_step, cfg.signed_mode);
    result.status = line_end.held_status;
    if (line_end.held_status != ST_OK) begin
      result.value = '0;
    end else if (line_end.negative_sign) begin
      result.value = VALUE_W'(0) - {1'b0, line_end.magnitude};
    end else begin
      result.value = {1'b0, line_end.magnitude};
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step.fire && step.last_byte)) begin
      line         <= LINE_CLEAR;
      key_position <= '0;
      for (int i = 0; i < HIST_DEPTH; i++) begin
        history[i] <= '0;
      end
    end else if (step.fire) begin
      line         <= line_step;
      key_position <= key_position_next;
      for (int i = 0; i < HIST_DEPTH; i++) begin
        history[i] <= history_next[i];
      end
    end
  end

endmodule

/* src/key_value_integer_extractor.sv */
// ----------------------------------------------------------------------------
// key_value_integer_extractor
// Finds the first "key=" at a word start in a text line and parses the
// decimal value that follows into a signed or unsigned 32-bit integer.
//
//  channel   dir  handshake                 payload
//  s_axis    in   s_axis_tvalid/tready      tdata: text_byte, tlast: last_byte
//  m_axis    out  m_axis_tvalid/tready      tdata: status, value
//  cfg       in   cfg_valid/cfg_ready       cfg_index, cfg_data
//
// One byte per cycle sustained unless a last byte waits on a stalled result: a byte sits
// in the input register; the scan state and the result register then update together.
// The result word of a line is presented in the cycle after its last byte is consumed.
// rst clears the line state and sets key_text 0, key_length 1, signed_mode 0.
// A stalled result holds the last byte of the next line in the input
// register; bytes that produce no result keep flowing.
// ----------------------------------------------------------------------------
module key_value_integer_extractor import kvie_pkg::*; #(
  parameter int KEY_MAX_BYTES = KEY_MAX_BYTES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [S_TDATA_W-1:0]   s_axis_tdata,   // [7:0] text_byte
  input  logic                   s_axis_tlast,   // last_byte
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [M_TDATA_W-1:0]   m_axis_tdata,   // [1:0] status, [34:2] value, rest zero
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [KEY_TEXT_W-1:0]  cfg_data
);

  kvie_cfg_t          cfg;
  kvie_step_t         step;
  kvie_result_t       result;

  logic               in_valid;
  logic [7:0]         in_byte;
  logic               in_last;
  logic               consume;

  logic               out_valid;
  status_t            out_status;
  logic [VALUE_W-1:0] out_value;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.key_text    <= '0;
      cfg.key_length  <= KEY_LEN_W'(1);
      cfg.signed_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_KEY_TEXT:    cfg.key_text    <= cfg_data;
        CFG_KEY_LENGTH:  cfg.key_length  <= cfg_data[KEY_LEN_W-1:0];
        CFG_SIGNED_MODE: cfg.signed_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // A last byte may only advance when the result register can take it.
  assign consume       = in_valid && (!in_last || !out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata[7:0];
      in_last <= s_axis_tlast;
    end
  end

  assign step.fire      = consume;
  assign step.text_byte = in_byte;
  assign step.last_byte = in_last;

  kvie_scan #(
    .KEY_MAX_BYTES (KEY_MAX_BYTES)
  ) u_scan (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (consume && in_last) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && in_last) begin
      out_status <= result.status;
      out_value  <= result.value;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {(M_TDATA_W - VALUE_W - STATUS_W)'(0), out_value, out_status};

endmodule

/* tb/key_value_integer_extractor_tb.sv */
// ----------------------------------------------------------------------------
// key_value_integer_extractor_tb
// Streams text lines into the extractor under several key, key length and
// sign settings, with random idling on both stream sides. A line model
// predicts the status and value word of every line, and each returned word
// is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
import kvie_pkg::*;

class kv_result_board;
  logic [KEY_TEXT_W-1:0] key_text;
  logic [KEY_LEN_W-1:0]  key_length;
  logic                  signed_mode;

  phase_t                phase;
  int unsigned           seen;
  logic [7:0]            recent [0:KEY_MAX_BYTES_DEF];
  logic [63:0]           mag;
  bit                    neg;
  bit                    ovf;
  bit                    fresh_eq;
  status_t               held;

  logic [M_TDATA_W-1:0]  awaited_words [$];
  int unsigned           fails;

  function new();
    key_text    = '0;
    key_length  = 4'd1;
    signed_mode = 1'b0;
    fails       = 0;
    clear_line();
  endfunction

  function void set_register(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [KEY_TEXT_W-1:0] data);
    case (idx)
      CFG_KEY_TEXT:    key_text = data;
      CFG_KEY_LENGTH:  key_length = data[KEY_LEN_W-1:0];
      CFG_SIGNED_MODE: signed_mode = data[0];
      default: ;
    endcase
  endfunction

  function bit is_space(input logic [7:0] b);
    return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  function void clear_line();
    phase = PH_SEEK;
    seen  = 0;
    foreach (recent[i]) recent[i] = 8'h00;
    mag      = 0;
    neg      = 0;
    ovf      = 0;
    fresh_eq = 0;
    held     = ST_NOKEY;
  endfunction

  // key must sit at the start of the line or right after whitespace
  function bit key_hit();
    int kl;
    kl = key_length;
    if (kl == 0) kl = 1;
    if (kl > KEY_MAX_BYTES_DEF) kl = KEY_MAX_BYTES_DEF;
    if (seen < kl) return 0;
    for (int i = 0; i < kl; i++) begin
      if (recent[kl-1-i] != key_text[8*i +: 8]) return 0;
    end
    return seen == kl || is_space(recent[kl]);
  endfunction

  function void push_digit(input int unsigned d);
    logic [63:0] m;
    if (!ovf) begin
      m = mag * 10 + d;
      if (m > 64'hFFFF_FFFF) ovf = 1;
      else mag = m;
    end
  endfunction

  function void close_digits(input bit term_ok);
    bit bad;
    bad = !term_ok || ovf;
    if (!bad) begin
      if (signed_mode) bad = neg ? (mag > {32'd0, INT_MIN_MAG}) : (mag > {32'd0, INT_MAX_MAG});
      else bad = neg && mag != 0;
    end
    if (bad) begin
      held = ST_PARSE;
      mag  = 0;
      neg  = 0;
    end else begin
      held = ST_OK;
    end
    phase = PH_DONE;
  endfunction

  function void close_empty();
    if (fresh_eq) held = ST_OK;
    mag   = 0;
    neg   = 0;
    phase = PH_DONE;
  endfunction

  function void scan(input logic [7:0] b);
    bit digit;
    digit = b >= CHAR_ZERO && b <= CHAR_NINE;
    case (phase)
      PH_SEEK: begin
        if (b == CHAR_EQUALS && key_hit()) begin
          phase    = PH_LEAD;
          fresh_eq = 1;
          mag      = 0;
          neg      = 0;
          ovf      = 0;
        end else begin
          for (int i = KEY_MAX_BYTES_DEF; i > 0; i--) recent[i] = recent[i-1];
          recent[0] = b;
          if (seen < KEY_MAX_BYTES_DEF + 1) seen++;
        end
      end
      PH_LEAD: begin
        if (fresh_eq) begin
          held     = is_space(b) ? ST_OK : ST_PARSE;
          fresh_eq = 0;
        end
        if (is_space(b)) begin
          // skip leading whitespace
        end else if (b == CHAR_PLUS || b == CHAR_MINUS) begin
          neg   = (b == CHAR_MINUS);
          phase = PH_SIGN;
        end else if (digit) begin
          push_digit(b - CHAR_ZERO);
          phase = PH_DIGITS;
        end else begin
          close_empty();
        end
      end
      PH_SIGN: begin
        if (digit) begin
          push_digit(b - CHAR_ZERO);
          phase = PH_DIGITS;
        end else begin
          close_empty();
        end
      end
      PH_DIGITS: begin
        if (digit) push_digit(b - CHAR_ZERO);
        else close_digits(is_space(b));
      end
      default: ;
    endcase
  endfunction

  function void end_of_text();
    case (phase)
      PH_SEEK: begin
        held  = ST_NOKEY;
        mag   = 0;
        neg   = 0;
        phase = PH_DONE;
      end
      PH_LEAD, PH_SIGN: close_empty();
      PH_DIGITS:        close_digits(1);
      default: ;
    endcase
  endfunction

  function void note_byte(input logic [7:0] b, input logic last);
    logic [VALUE_W-1:0]   v;
    logic [M_TDATA_W-1:0] w;
    if (b == CHAR_NUL) end_of_text();
    else scan(b);
    if (!last) return;
    end_of_text();
    v = mag[VALUE_W-1:0];
    if (held != ST_OK) v = '0;
    else if (neg) v = -v;
    w = '0;
    w[STATUS_W-1:0]        = held;
    w[STATUS_W +: VALUE_W] = v;
    awaited_words.push_back(w);
    clear_line();
  endfunction

  function void check_result(input logic [M_TDATA_W-1:0] got);
    logic [M_TDATA_W-1:0] w;
    if (awaited_words.size() == 0) begin
      $error("unexpected result word %h", got);
      fails++;
      return;
    end
    w = awaited_words.pop_front();
    if (got[STATUS_W-1:0] != w[STATUS_W-1:0]) begin
      $error("status: expected %0d, got %0d", w[STATUS_W-1:0], got[STATUS_W-1:0]);
      fails++;
    end
    if (got[STATUS_W +: VALUE_W] != w[STATUS_W +: VALUE_W]) begin
      $error("value: expected %0d, got %0d",
             $signed(w[STATUS_W +: VALUE_W]), $signed(got[STATUS_W +: VALUE_W]));
      fails++;
    end
    if (got[M_TDATA_W-1:STATUS_W+VALUE_W] != w[M_TDATA_W-1:STATUS_W+VALUE_W]) begin
      $error("pad: expected %h, got %h",
             w[M_TDATA_W-1:STATUS_W+VALUE_W], got[M_TDATA_W-1:STATUS_W+VALUE_W]);
      fails++;
    end
  endfunction
endclass

module key_value_integer_extractor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 1000;
  localparam int SETTLE_GAP  = 6;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [S_TDATA_W-1:0]   s_axis_tdata = '0;   // [7:0] text_byte
  logic                   s_axis_tlast = 1'b0; // last_byte
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]   m_axis_tdata;        // [1:0] status, [34:2] value, rest zero
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [KEY_TEXT_W-1:0]  cfg_data = '0;

  kv_result_board results_board = new();

  bit                     steady = 0;
  int                     quiet_cycles = 0;
  int unsigned            bytes_sent = 0;
  logic [7:0]             line_q [$];
  logic [KEY_TEXT_W-1:0]  gen_key_text = '0;
  int                     gen_key_len = 1;

  key_value_integer_extractor dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // result side: random stall, check every accepted word
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= steady || ($urandom_range(0, 99) >= 25);
      if (m_axis_tvalid && m_axis_tready) results_board.check_result(m_axis_tdata);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("key_value_integer_extractor_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [7:0] space_char();
    int unsigned r;
    r = $urandom_range(8, 13);
    return (r == 8) ? 8'h20 : 8'(r);
  endfunction

  function automatic logic [7:0] graphic_char();
    return 8'($urandom_range(33, 255));
  endfunction

  function automatic logic [KEY_TEXT_W-1:0] random_key();
    logic [KEY_TEXT_W-1:0] k;
    for (int i = 0; i < KEY_MAX_BYTES_DEF; i++) begin
      k[8*i +: 8] = graphic_char();
      if (k[8*i +: 8] == CHAR_EQUALS) k[8*i +: 8] = 8'h6B;
    end
    return k;
  endfunction

  function automatic void put_str(input string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endfunction

  function automatic void put_word();
    repeat ($urandom_range(1, 4)) line_q.push_back(graphic_char());
  endfunction

  function automatic void put_key();
    for (int i = 0; i < gen_key_len; i++) line_q.push_back(gen_key_text[8*i +: 8]);
  endfunction

  function automatic void put_value();
    longint unsigned mag;
    int              pick;
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 2)) line_q.push_back(space_char());
    end
    case ($urandom_range(0, 3))
      0: line_q.push_back(CHAR_MINUS);
      1: line_q.push_back(CHAR_PLUS);
      default: ;
    endcase
    pick = $urandom_range(0, 9);
    case (pick)
      0: mag = $urandom_range(0, 999);
      1, 2: begin
        case ($urandom_range(0, 7))
          0: mag = 64'd0;
          1: mag = 64'd1;
          2: mag = 64'd2147483647;
          3: mag = 64'd2147483648;
          4: mag = 64'd2147483649;
          5: mag = 64'd4294967295;
          6: mag = 64'd4294967296;
          default: mag = 64'd99999999999;
        endcase
      end
      3: mag = $urandom;
      4: mag = {$urandom, $urandom} % 64'd100000000000;
      5: begin
        put_str("00");
        mag = $urandom_range(0, 99);
      end
      6: return;  // sign or nothing, no digits
      default: mag = $urandom_range(0, 99999);
    endcase
    put_str($sformatf("%0d", mag));
  endfunction

  function automatic void build_line();
    line_q.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 10)) begin
        line_q.push_back(($urandom_range(0, 9) == 0) ? CHAR_NUL : 8'($urandom_range(1, 255)));
      end
      return;
    end
    repeat ($urandom_range(0, 2)) begin
      put_word();
      line_q.push_back(space_char());
    end
    // near misses ahead of the real key
    case ($urandom_range(0, 5))
      0: begin
        line_q.push_back(graphic_char());
        put_key();
        put_str("=1 ");
      end
      1: begin
        put_key();
        put_str("x=2 ");
      end
      2: begin
        put_key();
        line_q.push_back(space_char());
      end
      default: ;
    endcase
    put_key();
    line_q.push_back(CHAR_EQUALS);
    put_value();
    case ($urandom_range(0, 5))
      2, 3: begin
        line_q.push_back(space_char());
        if ($urandom_range(0, 1) != 0) put_word();
      end
      4: put_word();
      5: begin
        line_q.push_back(CHAR_NUL);
        put_word();
      end
      default: ;
    endcase
    if ($urandom_range(0, 24) == 0) begin
      line_q.insert($urandom_range(0, line_q.size() - 1), CHAR_NUL);
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    while (!steady && $urandom_range(0, 99) < 25) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    results_board.note_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_line();
    for (int i = 0; i < line_q.size(); i++) send_byte(line_q[i], i == line_q.size() - 1);
  endtask

  task automatic send_text(input string s);
    line_q.delete();
    put_str(s);
    send_line();
  endtask

  // hold input until every pending word has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (results_board.awaited_words.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [KEY_TEXT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    results_board.set_register(idx, data);
  endtask

  task automatic setup_regs(input logic [KEY_TEXT_W-1:0] kt, input logic [KEY_LEN_W-1:0] kl,
                            input logic sm);
    drain();
    repeat (SETTLE_GAP) @(posedge clk);
    write_reg(CFG_KEY_TEXT, kt);
    write_reg(CFG_KEY_LENGTH, KEY_TEXT_W'(kl));
    write_reg(CFG_SIGNED_MODE, KEY_TEXT_W'(sm));
    cfg_valid <= 1'b0;
    gen_key_text = kt;
    gen_key_len  = (kl == 0) ? 1 : (kl > KEY_MAX_BYTES_DEF) ? KEY_MAX_BYTES_DEF : int'(kl);
  endtask

  task automatic random_lines(input int unsigned budget, input bit pause_midway);
    int unsigned start;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      if (pause_midway && bytes_sent - start >= budget / 2) begin
        pause_midway = 0;
        drain();
      end
      build_line();
      send_line();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset settings: key is a single zero byte and never matches
    gen_key_text = '0;
    gen_key_len  = 1;
    random_lines(30, 0);

    setup_regs(64'h6B, 4'd1, 1'b0);
    send_text("k=");
    send_text("k=x");
    send_text("k=-0");
    send_text("k=+ 5");
    line_q.delete();
    line_q.push_back(CHAR_NUL);
    send_line();
    send_text("ak=1");
    send_text("k=1x");
    random_lines(70, 0);

    steady = 1;
    setup_regs(random_key(), 4'd8, 1'b1);
    random_lines(100, 0);
    steady = 0;

    setup_regs(random_key(), 4'd3, 1'b0);
    random_lines(100, 1);

    setup_regs({KEY_TEXT_W{1'b1}}, 4'd15, 1'b1);
    random_lines(80, 0);

    setup_regs(random_key(), 4'd0, 1'b0);
    random_lines(80, 0);

    setup_regs(random_key(), 4'($urandom_range(1, KEY_MAX_BYTES_DEF)), 1'b1);
    random_lines(80, 0);

    drain();
    repeat (SETTLE_GAP) @(posedge clk);
    if (results_board.fails == 0 && results_board.awaited_words.size() == 0) begin
      $display("key_value_integer_extractor_tb OK");
    end else begin
      $display("key_value_integer_extractor_tb NOT OK");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/kvie_pkg.sv
src/kvie_scan.sv
src/key_value_integer_extractor.sv
tb/key_value_integer_extractor_tb.sv
